FILE: rtl/ltps_pkg.sv
// Shared types and constants for the line tracking PI steering block.
// No dependencies; compiled before the interfaces and modules.
`timescale 1ns / 1ps

package ltps_pkg;

	localparam int unsigned LINE_WIDTH_DEF = 640;

	localparam int unsigned POS_W    = 10;
	localparam int unsigned SPEED_W  = 12;
	localparam int unsigned BASE_W   = 11;
	localparam int unsigned DB_W     = 10;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned LIM_W    = 10;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned TGT_W    = 11;
	localparam int unsigned INTEG_W  = 12;
	localparam int unsigned ERR_W    = 14;
	localparam int unsigned PROD_W   = 32;
	localparam int unsigned FRAC_W   = 10;
	localparam int unsigned CORR_W   = 22;
	localparam int unsigned SUM_W    = 24;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 5;

	localparam logic [BASE_W-1:0] BASE_SPEED_RST     = 11'd450;
	localparam logic [DB_W-1:0]   DEADBAND_RST       = 10'd10;
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 16'd819;
	localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST  = 16'd0;
	localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 10'd30;
	localparam logic [CNT_W-1:0]  LOST_LIMIT_RST     = 8'd10;
	localparam logic [TGT_W-1:0]  TARGET_RST         = 11'd0;

	typedef enum logic [2:0] {
		REG_BASE_SPEED     = 3'd0,
		REG_DEADBAND       = 3'd1,
		REG_PROP_GAIN      = 3'd2,
		REG_INTEGRAL_GAIN  = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_LOST_LIMIT     = 3'd5,
		REG_TARGET         = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] line_position;
		logic             line_found;
		logic             resume;
	} line_item_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] right_speed;
		logic signed [SPEED_W-1:0] left_speed;
		logic                      lost_event;
		logic                      halted;
	} steer_item_t;

endpackage

FILE: rtl/ltps_line_if.sv
// Valid/ready channel carrying one line sample per transaction.
// Depends on ltps_pkg.
`timescale 1ns / 1ps

interface ltps_line_if;
	logic                   valid;
	logic                   ready;
	ltps_pkg::line_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ltps_steer_if.sv
// Valid/ready channel carrying one steering command per transaction.
// Depends on ltps_pkg.
`timescale 1ns / 1ps

interface ltps_steer_if;
	logic                   valid;
	logic                   ready;
	ltps_pkg::steer_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/line_tracking_pi_steering.sv
// Line tracking PI steering: the input register feeds one pass of PI and lost-line logic
// into the result register; the integrator and lost counter update as the result is registered.
// Throughput one transaction per cycle while the output is not stalled by steer_out.ready.
// Asynchronous active-low reset clears the registers to defaults, the integral,
// the lost counter, the halt flag, the input-stage valid and the output valid.
// Depends on ltps_pkg, ltps_line_if, ltps_steer_if.
`timescale 1ns / 1ps

module line_tracking_pi_steering #(
	parameter int unsigned LINE_WIDTH = ltps_pkg::LINE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ltps_pkg::ADDR_W-1:0]  paddr,
	input  logic [ltps_pkg::DATA_W-1:0]  pwdata,
	output logic [ltps_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	ltps_line_if.sink                    line_in,
	ltps_steer_if.source                 steer_out
);
	import ltps_pkg::*;

	localparam logic signed [ERR_W-1:0] HALF = ERR_W'(LINE_WIDTH / 2);
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SPEED_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (SPEED_W - 1));
	localparam logic signed [PROD_W-1:0] ROUND_ADJ = PROD_W'((1 << FRAC_W) - 1);

	logic [BASE_W-1:0] base_speed_q;
	logic [DB_W-1:0]   deadband_q;
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] integral_gain_q;
	logic [LIM_W-1:0]  integral_limit_q;
	logic [CNT_W-1:0]  lost_limit_q;
	logic [TGT_W-1:0]  target_q;

	logic                      valid_s1;
	line_item_t                line_s1;
	logic                      rsp_valid_q;
	steer_item_t               rsp_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic [CNT_W-1:0]          lost_count_q;
	logic                      stopped_q;

	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;
	logic                      advance;
	logic                      take;

	logic [CNT_W-1:0]          cnt_base;
	logic                      stop_base;
	logic [CNT_W-1:0]          cnt_inc;
	logic                      hit;
	logic signed [ERR_W-1:0]   error;
	logic signed [ERR_W-1:0]   mag;
	logic                      in_db;
	logic signed [ERR_W-1:0]   acc_raw;
	logic signed [ERR_W-1:0]   lim;
	logic signed [ERR_W-1:0]   acc;
	logic signed [PROD_W-1:0]  prod_p;
	logic signed [PROD_W-1:0]  prod_i;
	logic signed [PROD_W-1:0]  total;
	logic signed [PROD_W-1:0]  total_adj;
	logic signed [PROD_W-1:0]  corr_full;
	logic signed [CORR_W-1:0]  corr;
	logic signed [SUM_W-1:0]   base_ext;
	logic signed [SUM_W-1:0]   corr_ext;
	logic signed [SUM_W-1:0]   right_raw;
	logic signed [SUM_W-1:0]   left_raw;
	steer_item_t               result;
	logic                      integ_upd;

	function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SUM_W-1:0] v);
		logic signed [SPEED_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[SPEED_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[SPEED_W-1:0];
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q     <= BASE_SPEED_RST;
			deadband_q       <= DEADBAND_RST;
			prop_gain_q      <= PROP_GAIN_RST;
			integral_gain_q  <= INTEGRAL_GAIN_RST;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			lost_limit_q     <= LOST_LIMIT_RST;
			target_q         <= TARGET_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BASE_SPEED:     base_speed_q     <= pwdata[BASE_W-1:0];
				REG_DEADBAND:       deadband_q       <= pwdata[DB_W-1:0];
				REG_PROP_GAIN:      prop_gain_q      <= pwdata[GAIN_W-1:0];
				REG_INTEGRAL_GAIN:  integral_gain_q  <= pwdata[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= pwdata[LIM_W-1:0];
				REG_LOST_LIMIT:     lost_limit_q     <= pwdata[CNT_W-1:0];
				REG_TARGET:         target_q         <= pwdata[TGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BASE_SPEED:     prdata = DATA_W'(base_speed_q);
			REG_DEADBAND:       prdata = DATA_W'(deadband_q);
			REG_PROP_GAIN:      prdata = DATA_W'(prop_gain_q);
			REG_INTEGRAL_GAIN:  prdata = DATA_W'(integral_gain_q);
			REG_INTEGRAL_LIMIT: prdata = DATA_W'(integral_limit_q);
			REG_LOST_LIMIT:     prdata = DATA_W'(lost_limit_q);
			REG_TARGET:         prdata = {{(DATA_W-TGT_W){target_q[TGT_W-1]}}, target_q};
			default:            prdata = '0;
		endcase
	end

	assign advance         = !rsp_valid_q || steer_out.ready;
	assign line_in.ready   = !valid_s1 || advance;
	assign take            = line_in.valid && line_in.ready;
	assign steer_out.valid = rsp_valid_q;
	assign steer_out.data  = rsp_q;

	always_comb begin
		cnt_base  = line_s1.resume ? '0 : lost_count_q;
		stop_base = line_s1.resume ? 1'b0 : stopped_q;
		cnt_inc   = cnt_base + 1'b1;
		hit       = (cnt_inc == lost_limit_q);

		error = $signed({{(ERR_W-POS_W){1'b0}}, line_s1.line_position}) - HALF
			- $signed({{(ERR_W-TGT_W){target_q[TGT_W-1]}}, target_q});
		mag   = error[ERR_W-1] ? -error : error;
		in_db = mag < $signed({{(ERR_W-DB_W){1'b0}}, deadband_q});

		acc_raw = $signed({{(ERR_W-INTEG_W){integral_q[INTEG_W-1]}}, integral_q}) + error;
		lim     = $signed({{(ERR_W-LIM_W){1'b0}}, integral_limit_q});
		if (acc_raw > lim) begin
			acc = lim;
		end else if (acc_raw < -lim) begin
			acc = -lim;
		end else begin
			acc = acc_raw;
		end

		prod_p = $signed({{(PROD_W-GAIN_W){1'b0}}, prop_gain_q})
			* $signed({{(PROD_W-ERR_W){error[ERR_W-1]}}, error});
		prod_i = $signed({{(PROD_W-GAIN_W){1'b0}}, integral_gain_q})
			* $signed({{(PROD_W-ERR_W){acc[ERR_W-1]}}, acc});
		total     = prod_p + prod_i;
		total_adj = total[PROD_W-1] ? total + ROUND_ADJ : total;
		corr_full = total_adj >>> FRAC_W;
		corr      = in_db ? '0 : corr_full[CORR_W-1:0];

		base_ext  = $signed({{(SUM_W-BASE_W){1'b0}}, base_speed_q});
		corr_ext  = {{(SUM_W-CORR_W){corr[CORR_W-1]}}, corr};
		right_raw = base_ext - corr_ext;
		left_raw  = base_ext + corr_ext;

		result    = '0;
		integ_upd = 1'b0;
		if (stop_base) begin
			result.halted = 1'b1;
		end else if (hit) begin
			result.halted     = 1'b1;
			result.lost_event = 1'b1;
		end else begin
			result.right_speed = sat_speed(right_raw);
			result.left_speed  = sat_speed(left_raw);
			integ_upd          = !in_db;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			line_s1 <= line_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			integral_q   <= '0;
			lost_count_q <= '0;
			stopped_q    <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				stopped_q <= stop_base || hit;
				if (stop_base) begin
					lost_count_q <= cnt_base;
				end else if (hit || !line_s1.line_found) begin
					lost_count_q <= cnt_inc;
				end else begin
					lost_count_q <= '0;
				end
				if (integ_upd) begin
					integral_q <= acc[INTEG_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= result;
		end
	end

endmodule

FILE: rtl/ltps_chk.sv
// Port-level checker for line_tracking_pi_steering, bound to the top level.
// Depends on ltps_pkg and line_tracking_pi_steering.
`timescale 1ns / 1ps

module ltps_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   pready,
	input logic                   out_valid,
	input logic                   out_ready,
	input ltps_pkg::steer_item_t  out_data
);
	import ltps_pkg::*;

	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.halted |-> out_data.right_speed == '0 && out_data.left_speed == '0)
		else $error("halted result with nonzero speed");

	a_lost_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lost_event |-> out_data.halted)
		else $error("lost event without halt");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result transaction changed");

endmodule

bind line_tracking_pi_steering ltps_chk u_ltps_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (steer_out.valid),
	.out_ready (steer_out.ready),
	.out_data  (steer_out.data)
);
